### sv/qrm_pkg.sv
// Package for the quaternion rotate/multiply pipeline: payload types, kind codes
// and the saturating Q16.16 helpers shared by the pipeline stages. No dependencies.
package qrm_pkg;

  typedef enum logic [1:0] {
    KIND_MUL    = 2'd0,
    KIND_ROT    = 2'd1,
    KIND_ROT_W  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] a_w;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_w;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] r_w;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
  } out_t;

  typedef struct packed {
    logic signed [31:0] w;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } quat_t;

  localparam logic signed [31:0] QOne = 32'sh0001_0000;
  localparam logic signed [31:0] SMax = 32'sh7fff_ffff;
  localparam logic signed [31:0] SMin = 32'sh8000_0000;

  // Saturate a 36-bit sum to 32 bits.
  function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sh0_7fff_ffff) r = SMax;
    else if (v < -36'sh0_8000_0000) r = SMin;
    else r = v[31:0];
    return r;
  endfunction

  // Product of two Q16.16 values, floored and saturated.
  function automatic logic signed [31:0] fmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    logic signed [47:0] s;
    logic signed [31:0] r;
    p = a * b;
    s = p[63:16];
    if (s > 48'sh0000_7fff_ffff) r = SMax;
    else if (s < -48'sh0000_8000_0000) r = SMin;
    else r = s[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] neg_sat(input logic signed [31:0] a);
    logic signed [31:0] r;
    r = (a == SMin) ? SMax : -a;
    return r;
  endfunction

  // Four saturated products summed with the given signs.
  function automatic logic signed [31:0] sum4(input logic signed [31:0] p0,
      input logic signed [31:0] p1, input logic signed [31:0] p2,
      input logic signed [31:0] p3, input logic [3:0] sub);
    logic signed [35:0] acc;
    acc = 36'(p0);
    acc = sub[1] ? acc - 36'(p1) : acc + 36'(p1);
    acc = sub[2] ? acc - 36'(p2) : acc + 36'(p2);
    acc = sub[3] ? acc - 36'(p3) : acc + 36'(p3);
    return sat36(acc);
  endfunction

endpackage

### sv/qrm_qmul.sv
// Two-stage Hamilton product l*r with a stall-aware valid pipeline.
// Depends on qrm_pkg. A side field travels alongside the operands.
module qrm_qmul (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  qrm_pkg::quat_t   l_i,
  input  qrm_pkg::quat_t   r_i,
  input  qrm_pkg::quat_t   side_i,
  output logic             valid_o,
  output qrm_pkg::quat_t   p_o,
  output qrm_pkg::quat_t   side_o
);

  logic signed [31:0] pr_d [16];
  logic signed [31:0] pr_q [16];
  qrm_pkg::quat_t side_q, side2_q, p_q;
  logic v1_q, v2_q;

  // Stage one: sixteen elementary products.
  always_comb begin
    pr_d[0]  = qrm_pkg::fmul(l_i.w, r_i.w);
    pr_d[1]  = qrm_pkg::fmul(l_i.x, r_i.x);
    pr_d[2]  = qrm_pkg::fmul(l_i.y, r_i.y);
    pr_d[3]  = qrm_pkg::fmul(l_i.z, r_i.z);
    pr_d[4]  = qrm_pkg::fmul(l_i.w, r_i.x);
    pr_d[5]  = qrm_pkg::fmul(l_i.x, r_i.w);
    pr_d[6]  = qrm_pkg::fmul(l_i.y, r_i.z);
    pr_d[7]  = qrm_pkg::fmul(l_i.z, r_i.y);
    pr_d[8]  = qrm_pkg::fmul(l_i.w, r_i.y);
    pr_d[9]  = qrm_pkg::fmul(l_i.x, r_i.z);
    pr_d[10] = qrm_pkg::fmul(l_i.y, r_i.w);
    pr_d[11] = qrm_pkg::fmul(l_i.z, r_i.x);
    pr_d[12] = qrm_pkg::fmul(l_i.w, r_i.z);
    pr_d[13] = qrm_pkg::fmul(l_i.x, r_i.y);
    pr_d[14] = qrm_pkg::fmul(l_i.y, r_i.x);
    pr_d[15] = qrm_pkg::fmul(l_i.z, r_i.w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  // Stage two: signed sums per component.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pr_q    <= pr_d;
      side_q  <= side_i;
      p_q.w   <= qrm_pkg::sum4(pr_q[0], pr_q[1], pr_q[2], pr_q[3], 4'b1110);
      p_q.x   <= qrm_pkg::sum4(pr_q[4], pr_q[5], pr_q[6], pr_q[7], 4'b1000);
      p_q.y   <= qrm_pkg::sum4(pr_q[8], pr_q[9], pr_q[10], pr_q[11], 4'b0010);
      p_q.z   <= qrm_pkg::sum4(pr_q[12], pr_q[13], pr_q[14], pr_q[15], 4'b0100);
      side2_q <= side_q;
    end
  end

  assign valid_o = v2_q;
  assign p_o     = p_q;
  assign side_o  = side2_q;

endmodule

### sv/qrm_front.sv
// Front end: rebuilds w for kind 2 (pipelined square root), squared magnitude and
// a pipelined restoring divide for the reciprocal, then forms the inverse. Uses qrm_pkg.
module qrm_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  qrm_pkg::in_t   item_i,
  output logic           valid_o,
  output logic [1:0]     kind_o,
  output qrm_pkg::quat_t a_o,
  output qrm_pkg::quat_t b_o,
  output qrm_pkg::quat_t inv_o
);

  localparam int unsigned SqSteps  = 24; // result bits of sqrt(s << 16), s <= 2^16
  localparam int unsigned DivSteps = 33; // quotient bits of 2^32 / mag

  typedef struct packed {
    logic           v;
    logic [1:0]     kind;
    qrm_pkg::quat_t a;
    qrm_pkg::quat_t b;
  } ctx_t;

  // Stage A: squares of the vector part.
  ctx_t a_q;
  logic signed [31:0] sx_q, sy_q, sz_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
    end else if (en_i) begin
      a_q.v    <= valid_i;
      a_q.kind <= item_i.kind;
      a_q.a    <= '{item_i.a_w, item_i.a_x, item_i.a_y, item_i.a_z};
      a_q.b    <= '{(item_i.kind == qrm_pkg::KIND_MUL) ? item_i.b_w : 32'sd0,
                    item_i.b_x, item_i.b_y, item_i.b_z};
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx_q     <= qrm_pkg::fmul(item_i.a_x, item_i.a_x);
      sy_q     <= qrm_pkg::fmul(item_i.a_y, item_i.a_y);
      sz_q     <= qrm_pkg::fmul(item_i.a_z, item_i.a_z);
    end
  end

  // Stage B: unit remainder s = 1 - x^2 - y^2 - z^2.
  ctx_t b_q;
  logic signed [35:0] s_d;
  logic [47:0] rad_q;
  logic neg_q;
  assign s_d = 36'(qrm_pkg::QOne) - 36'(sx_q) - 36'(sy_q) - 36'(sz_q);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_q <= '0;
    else if (en_i) b_q <= a_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q    <= s_d[35];
      rad_q    <= s_d[35] ? 48'd0 : {s_d[31:0], 16'd0};
    end
  end

  // Square root, two result bits per pipeline stage, one digit per step.
  ctx_t sq_ctx_q [SqSteps/2];
  logic [47:0] sq_rem_q [SqSteps/2];
  logic [23:0] sq_res_q [SqSteps/2];
  logic        sq_neg_q [SqSteps/2];

  function automatic void sq_step(input logic [47:0] rem, input logic [23:0] res,
                                  input int unsigned k,
                                  output logic [47:0] rem_o, output logic [23:0] res_o);
    logic [49:0] trial;
    logic [49:0] top;
    trial = {24'd0, res, 2'b01} << (2 * k);
    top   = {2'b00, rem};
    if (top >= trial) begin
      rem_o = 48'(top - trial);
      res_o = {res[22:0], 1'b1};
    end else begin
      rem_o = rem;
      res_o = {res[22:0], 1'b0};
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SqSteps / 2; i++) sq_ctx_q[i] <= '0;
    end else if (en_i) begin
      sq_ctx_q[0] <= b_q;
      for (int i = 1; i < SqSteps / 2; i++) sq_ctx_q[i] <= sq_ctx_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    logic [47:0] r1, r2;
    logic [23:0] q1, q2;
    if (en_i) begin
      sq_step(rad_q, 24'd0, SqSteps - 1, r1, q1);
      sq_step(r1, q1, SqSteps - 2, r2, q2);
      sq_rem_q[0] <= r2;
      sq_res_q[0] <= q2;
      sq_neg_q[0] <= neg_q;
      for (int i = 1; i < SqSteps / 2; i++) begin
        sq_step(sq_rem_q[i-1], sq_res_q[i-1], SqSteps - 1 - 2 * i, r1, q1);
        sq_step(r1, q1, SqSteps - 2 - 2 * i, r2, q2);
        sq_rem_q[i] <= r2;
        sq_res_q[i] <= q2;
        sq_neg_q[i] <= sq_neg_q[i-1];
      end
    end
  end

  // Stage C: pick w, compute the four squares of the magnitude.
  localparam int unsigned SqLast = SqSteps / 2 - 1;
  ctx_t c_q;
  logic signed [31:0] w_sel;
  logic signed [31:0] m0_q, m1_q, m2_q, m3_q;
  always_comb begin
    w_sel = sq_ctx_q[SqLast].a.w;
    if (sq_ctx_q[SqLast].kind == qrm_pkg::KIND_ROT_W)
      w_sel = sq_neg_q[SqLast] ? 32'sd0 : -$signed({8'd0, sq_res_q[SqLast]});
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q <= '0;
    end else if (en_i) begin
      c_q.v    <= sq_ctx_q[SqLast].v;
      c_q.kind <= sq_ctx_q[SqLast].kind;
      c_q.a    <= '{w_sel, sq_ctx_q[SqLast].a.x, sq_ctx_q[SqLast].a.y,
                    sq_ctx_q[SqLast].a.z};
      c_q.b    <= sq_ctx_q[SqLast].b;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m0_q <= qrm_pkg::fmul(w_sel, w_sel);
      m1_q <= qrm_pkg::fmul(sq_ctx_q[SqLast].a.x, sq_ctx_q[SqLast].a.x);
      m2_q <= qrm_pkg::fmul(sq_ctx_q[SqLast].a.y, sq_ctx_q[SqLast].a.y);
      m3_q <= qrm_pkg::fmul(sq_ctx_q[SqLast].a.z, sq_ctx_q[SqLast].a.z);
    end
  end

  // Stage D: saturated magnitude; zero or negative selects 1.0 later.
  ctx_t d_q;
  logic signed [31:0] mag_d;
  logic [31:0] mag_q;
  logic zmag_q;
  assign mag_d = qrm_pkg::sum4(m0_q, m1_q, m2_q, m3_q, 4'b0000);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) d_q <= '0;
    else if (en_i) d_q <= c_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zmag_q   <= (mag_d <= 32'sd0);
      mag_q    <= (mag_d <= 32'sd0) ? 32'd1 : mag_d;
    end
  end

  // Restoring divide of 2^32 by mag, three quotient bits per stage.
  localparam int unsigned DivStages = DivSteps / 3;
  ctx_t dv_ctx_q [DivStages];
  logic [32:0] dv_rem_q [DivStages];
  logic [32:0] dv_quo_q [DivStages];
  logic [31:0] dv_den_q [DivStages];
  logic        dv_z_q   [DivStages];

  // Dividend bit k of 2^32 is set only for k == 32.
  function automatic void dv_step(input logic [32:0] rem, input logic [32:0] quo,
                                  input logic [31:0] den, input int unsigned k,
                                  output logic [32:0] rem_o, output logic [32:0] quo_o);
    logic [33:0] t;
    t = {rem, (k == 32) ? 1'b1 : 1'b0};
    if (t >= {2'b00, den}) begin
      rem_o = 33'(t - {2'b00, den});
      quo_o = {quo[31:0], 1'b1};
    end else begin
      rem_o = t[32:0];
      quo_o = {quo[31:0], 1'b0};
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DivStages; i++) dv_ctx_q[i] <= '0;
    end else if (en_i) begin
      dv_ctx_q[0] <= d_q;
      for (int i = 1; i < DivStages; i++) dv_ctx_q[i] <= dv_ctx_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    logic [32:0] r1, r2, r3, q1, q2, q3;
    if (en_i) begin
      dv_step(33'd0, 33'd0, mag_q, 32, r1, q1);
      dv_step(r1, q1, mag_q, 31, r2, q2);
      dv_step(r2, q2, mag_q, 30, r3, q3);
      dv_rem_q[0] <= r3;
      dv_quo_q[0] <= q3;
      dv_den_q[0] <= mag_q;
      dv_z_q[0]   <= zmag_q;
      for (int i = 1; i < DivStages; i++) begin
        dv_step(dv_rem_q[i-1], dv_quo_q[i-1], dv_den_q[i-1], 32 - 3 * i, r1, q1);
        dv_step(r1, q1, dv_den_q[i-1], 31 - 3 * i, r2, q2);
        dv_step(r2, q2, dv_den_q[i-1], 30 - 3 * i, r3, q3);
        dv_rem_q[i] <= r3;
        dv_quo_q[i] <= q3;
        dv_den_q[i] <= dv_den_q[i-1];
        dv_z_q[i]   <= dv_z_q[i-1];
      end
    end
  end

  // Stage E: saturate reciprocal, form the inverse.
  localparam int unsigned DvLast = DivStages - 1;
  ctx_t e_q;
  qrm_pkg::quat_t inv_q;
  logic signed [31:0] rcp;
  always_comb begin
    if (dv_z_q[DvLast]) rcp = qrm_pkg::QOne;
    else if (dv_quo_q[DvLast][32:31] != 2'b00) rcp = qrm_pkg::SMax;
    else rcp = $signed(dv_quo_q[DvLast][31:0]);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) e_q <= '0;
    else if (en_i) e_q <= dv_ctx_q[DvLast];
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      inv_q.w  <= qrm_pkg::fmul(dv_ctx_q[DvLast].a.w, rcp);
      inv_q.x  <= qrm_pkg::fmul(qrm_pkg::neg_sat(dv_ctx_q[DvLast].a.x), rcp);
      inv_q.y  <= qrm_pkg::fmul(qrm_pkg::neg_sat(dv_ctx_q[DvLast].a.y), rcp);
      inv_q.z  <= qrm_pkg::fmul(qrm_pkg::neg_sat(dv_ctx_q[DvLast].a.z), rcp);
    end
  end

  assign valid_o = e_q.v;
  assign kind_o  = e_q.kind;
  assign a_o     = e_q.a;
  assign b_o     = e_q.b;
  assign inv_o   = inv_q;

endmodule

### sv/quaternion_rotate_multiply.sv
// Quaternion rotate/multiply unit, Q16.16 fixed point.
//
// Input channel in_valid_i/in_stall_o carries a qrm_pkg::in_t; a transfer happens
// on a rising edge with valid high and stall low. Output channel out_valid_o /
// out_stall_i carries a qrm_pkg::out_t, one result per input item, in order.
// Kind 0 gives the Hamilton product a*b, kind 1 rotates vector b by a as
// a*b*inv(a), kind 2 first rebuilds a.w from the vector part. Kind 3 gives zeros.
// Every kind takes the same path: the front end (squares, 12-stage square root,
// magnitude, 11-stage reciprocal divider, inverse) is 28 register stages, and two
// 2-stage quaternion multipliers follow before the output register. One item is
// accepted every cycle unless the pipeline is stalled. The whole pipeline advances
// together: when the output register holds a result and the receiver stalls,
// every stage freezes and in_stall_o rises; no item is lost or repeated. Reset
// empties all valid bits.
// Depends on qrm_pkg, qrm_front and qrm_qmul.
module quaternion_rotate_multiply (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  qrm_pkg::in_t in_data_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output qrm_pkg::out_t out_data_o
);

  logic en;
  logic f_v, m1_v, m2_v;
  logic [1:0] f_kind;
  qrm_pkg::quat_t f_a, f_b, f_inv, m1_p, m1_side, m2_p, m2_side;
  logic out_v_q;
  qrm_pkg::out_t out_q;

  // The pipeline moves when the output register is empty or being taken.
  assign en         = !out_v_q || !out_stall_i;
  assign in_stall_o = !en;

  qrm_front u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .item_i(in_data_i),
    .valid_o(f_v), .kind_o(f_kind), .a_o(f_a), .b_o(f_b), .inv_o(f_inv)
  );

  // Kind 0 multiplies by identity in the second pass.
  qrm_pkg::quat_t side_in;
  always_comb begin
    side_in = f_inv;
    if (f_kind == qrm_pkg::KIND_MUL) side_in = '{qrm_pkg::QOne, 32'sd0, 32'sd0, 32'sd0};
    side_in.w = (f_kind == qrm_pkg::KIND_NONE) ? 32'sd0 : side_in.w;
  end

  qrm_qmul u_mul1 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(f_v), .l_i(f_a), .r_i(f_b), .side_i(side_in),
    .valid_o(m1_v), .p_o(m1_p), .side_o(m1_side)
  );

  // Kind 3 zeroes the side quaternion entirely, so its product is zero.
  qrm_pkg::quat_t r2;
  logic kill_q [2];
  always_ff @(posedge clk_i) begin
    if (en) begin
      kill_q[0] <= (f_kind == qrm_pkg::KIND_NONE);
      kill_q[1] <= kill_q[0];
    end
  end
  assign r2 = kill_q[1] ? '0 : m1_side;

  qrm_qmul u_mul2 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(m1_v), .l_i(m1_p), .r_i(r2), .side_i(m1_side),
    .valid_o(m2_v), .p_o(m2_p), .side_o(m2_side)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= m2_v;
  end
  always_ff @(posedge clk_i) begin
    if (en) out_q <= '{m2_p.w, m2_p.x, m2_p.y, m2_p.z};
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // A stalled result stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("held result changed");
  // Input stall only when a result waits under stall.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("spurious input stall");
  // Kind 3 items entering the first multiplier are marked for zeroing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && f_v && f_kind == qrm_pkg::KIND_NONE |=> kill_q[0])
    else $error("kill flag lost");

endmodule
